// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list block: action and status
// codes, payload field widths.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int ACT_W  = 3;
	localparam int POS_W  = 7;
	localparam int WORD_W = 32;
	localparam int ST_W   = 2;

	typedef logic [ACT_W-1:0]         action_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [ST_W-1:0]          status_t;

	localparam action_t ACT_APPEND = 3'd0;
	localparam action_t ACT_DROP   = 3'd1;
	localparam action_t ACT_INSERT = 3'd2;
	localparam action_t ACT_REMOVE = 3'd3;
	localparam action_t ACT_READ   = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_RANGE     = 2'd1;
	localparam status_t ST_FULLEMPTY = 2'd2;

endpackage

// ===== rtl/ilir_ram.sv =====
// ----------------------------------------------------------------------------
// ilir_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ilir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
// Sequence: append, drop, rejected and unused requests pass from the check state
// straight to the result state; read passes through a RAM read wait; insert and
// remove sweep in the shift state, one RAM read and one write-back per word
// shifted.
// Throughput: one request in flight; in_stall is high until the result is loaded.
// Reset: arst_n clears the word count and control; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Ordered list of signed words in a single RAM with a word count. Insert and
// remove sweep the tail through the RAM, reading one entry and writing the
// previous one each cycle.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ilir_pkg::action_t   action,
	input  ilir_pkg::pos_t      position,
	input  ilir_pkg::word_t     word_in,
	output logic                out_valid,
	input  logic                out_stall,
	output ilir_pkg::word_t     word_out,
	output ilir_pkg::status_t   status,
	output ilir_pkg::pos_t      length
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
	localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	ilir_pkg::action_t   act_q;
	ilir_pkg::pos_t      pos_q;
	ilir_pkg::word_t     word_q;
	ilir_pkg::word_t     res_word_q;
	ilir_pkg::status_t   res_st_q;
	logic [CW-1:0]       left_q;
	logic [AW-1:0]       ptr_q;
	logic                shift_pend_s1;
	logic [AW-1:0]       shift_waddr_s1;

	logic                out_valid_q;
	ilir_pkg::word_t     word_out_q;
	ilir_pkg::status_t   status_q;
	ilir_pkg::pos_t      length_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ilir_pkg::WORD_W-1:0] ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [ilir_pkg::WORD_W-1:0] ram_rdata;

	logic [CMPW-1:0]     pos_ext;
	logic [CMPW-1:0]     cnt_ext;
	logic                full;
	logic                empty;
	logic                pos_gt_cnt;
	logic                pos_ge_cnt;
	logic                is_insert;
	logic                out_free;

	assign pos_ext    = CMPW'(pos_q);
	assign cnt_ext    = CMPW'(count_q);
	assign full       = (count_q == DEPTH_CW);
	assign empty      = (count_q == '0);
	assign pos_gt_cnt = (pos_ext > cnt_ext);
	assign pos_ge_cnt = (pos_ext >= cnt_ext);
	assign is_insert  = (act_q == ilir_pkg::ACT_INSERT);
	assign out_free   = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign word_out  = word_out_q;
	assign status    = status_q;
	assign length    = length_q;

	ilir_ram #(
		.WIDTH(ilir_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_CHECK: begin
				if (act_q == ilir_pkg::ACT_APPEND && !full) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_ext[AW-1:0];
					ram_wdata = word_q;
				end
				if (act_q == ilir_pkg::ACT_READ && !empty && !pos_ge_cnt) begin
					ram_re    = 1'b1;
					ram_raddr = pos_ext[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (left_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q;
				end
				if (shift_pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = shift_waddr_s1;
					ram_wdata = ram_rdata;
				end else if (left_q == '0 && is_insert) begin
					// tail moved up; drop the new word into the gap
					ram_we    = 1'b1;
					ram_waddr = pos_ext[AW-1:0];
					ram_wdata = word_q;
				end
			end
			default: begin
			end
		endcase
	end

	// request payload, result and sweep registers, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_q  <= action;
			pos_q  <= position;
			word_q <= word_in;
		end
		if (state_q == S_CHECK) begin
			res_word_q <= '0;
			res_st_q   <= ilir_pkg::ST_OK;
			unique case (act_q) inside
				ilir_pkg::ACT_APPEND: begin
					if (full) res_st_q <= ilir_pkg::ST_FULLEMPTY;
				end
				ilir_pkg::ACT_DROP: begin
					if (empty) res_st_q <= ilir_pkg::ST_FULLEMPTY;
				end
				ilir_pkg::ACT_INSERT: begin
					if (full) res_st_q <= ilir_pkg::ST_FULLEMPTY;
					else if (pos_gt_cnt) res_st_q <= ilir_pkg::ST_RANGE;
					left_q <= CW'(cnt_ext - pos_ext);
					ptr_q  <= cnt_ext[AW-1:0] - AW'(1);
				end
				ilir_pkg::ACT_REMOVE, ilir_pkg::ACT_READ: begin
					if (empty) res_st_q <= ilir_pkg::ST_FULLEMPTY;
					else if (pos_ge_cnt) res_st_q <= ilir_pkg::ST_RANGE;
					left_q <= CW'(cnt_ext - pos_ext - CMPW'(1));
					ptr_q  <= pos_ext[AW-1:0] + AW'(1);
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_SHIFT && left_q != '0) begin
			left_q         <= left_q - CW'(1);
			ptr_q          <= is_insert ? ptr_q - AW'(1) : ptr_q + AW'(1);
			shift_waddr_s1 <= is_insert ? ptr_q + AW'(1) : ptr_q - AW'(1);
		end
		if (state_q == S_RDWAIT) begin
			res_word_q <= ram_rdata;
		end
		if (state_q == S_RESULT && out_free) begin
			word_out_q <= res_word_q;
			status_q   <= res_st_q;
			length_q   <= cnt_ext[ilir_pkg::POS_W-1:0];
		end
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			shift_pend_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// in S_RESULT the load below decides out_valid_q
			if (out_valid_q && !out_stall && state_q != S_RESULT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= S_RESULT;
					unique case (act_q)
						ilir_pkg::ACT_APPEND: begin
							if (!full) count_q <= count_q + CW'(1);
						end
						ilir_pkg::ACT_DROP: begin
							if (!empty) count_q <= count_q - CW'(1);
						end
						ilir_pkg::ACT_INSERT: begin
							if (!full && !pos_gt_cnt) state_q <= S_SHIFT;
						end
						ilir_pkg::ACT_REMOVE: begin
							if (!empty && !pos_ge_cnt) state_q <= S_SHIFT;
						end
						ilir_pkg::ACT_READ: begin
							if (!empty && !pos_ge_cnt) state_q <= S_RDWAIT;
						end
						default: begin
						end
					endcase
				end
				S_SHIFT: begin
					shift_pend_s1 <= (left_q != '0);
					if (left_q == '0 && !shift_pend_s1) begin
						state_q <= S_RESULT;
						count_q <= is_insert ? count_q + CW'(1) : count_q - CW'(1);
					end
				end
				S_RDWAIT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CW)
		else $error("word count above depth");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RESULT) |-> !ram_we)
		else $error("RAM write outside a request");

	a_pend_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		shift_pend_s1 |-> state_q == S_SHIFT)
		else $error("shift write-back pending outside sweep");

	a_word_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && word_out_q != '0 |-> status_q == ilir_pkg::ST_OK)
		else $error("nonzero word with error status");
`endif

endmodule

// ===== sim/indexed_list_checker.sv =====
// ----------------------------------------------------------------------------
// indexed_list_checker
// Watches both channels of the indexed list block. Keeps its own copy of the
// list, works out the result of every accepted request and compares each
// result transfer against the oldest one still awaited.
// ----------------------------------------------------------------------------
module indexed_list_checker
	import ilir_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_stall,
	input  action_t action,
	input  pos_t    position,
	input  word_t   word_in,
	input  logic    out_valid,
	input  logic    out_stall,
	input  word_t   word_out,
	input  status_t status,
	input  pos_t    length,
	output int      errors,
	output int      fill,
	output int      waiting,
	output int      checked,
	output int      range_rejects,
	output int      capacity_rejects
);

	typedef struct packed {
		word_t   word;
		status_t st;
		pos_t    len;
	} list_result_t;

	word_t        shadow_words [DEPTH];
	list_result_t awaited_results [$];
	list_result_t want;

	// Applies one request to the shadow list and returns what the block owes.
	function automatic list_result_t predict_list_op(action_t act, pos_t pos, word_t val);
		list_result_t r;
		r = '0;
		r.st = ST_OK;
		case (act)
		ACT_APPEND: begin
			if (fill >= DEPTH)
				r.st = ST_FULLEMPTY;
			else begin
				shadow_words[fill] = val;
				fill++;
			end
		end
		ACT_DROP: begin
			if (fill == 0)
				r.st = ST_FULLEMPTY;
			else
				fill--;
		end
		ACT_INSERT: begin
			// fullness wins over a bad index
			if (fill >= DEPTH)
				r.st = ST_FULLEMPTY;
			else if (int'(pos) > fill)
				r.st = ST_RANGE;
			else begin
				for (int i = fill; i > int'(pos); i--)
					shadow_words[i] = shadow_words[i-1];
				shadow_words[pos] = val;
				fill++;
			end
		end
		ACT_REMOVE: begin
			if (fill == 0)
				r.st = ST_FULLEMPTY;
			else if (int'(pos) >= fill)
				r.st = ST_RANGE;
			else begin
				for (int i = int'(pos); i + 1 < fill; i++)
					shadow_words[i] = shadow_words[i+1];
				fill--;
			end
		end
		ACT_READ: begin
			if (fill == 0)
				r.st = ST_FULLEMPTY;
			else if (int'(pos) >= fill)
				r.st = ST_RANGE;
			else
				r.word = shadow_words[pos];
		end
		default: ; // spare codes leave everything alone
		endcase
		r.len = pos_t'(fill);
		return r;
	endfunction

	// Blocking updates here; the stimulus side reads these counters at negedge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			waiting = 0;
			awaited_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer: word_out %0d status %0d length %0d",
						$time, word_out, status, length);
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (word_out !== want.word) begin
						errors++;
						$display("%0t: word_out expected %0d, got %0d", $time, want.word, word_out);
					end
					if (status !== want.st) begin
						errors++;
						$display("%0t: status expected %0d, got %0d", $time, want.st, status);
					end
					if (length !== want.len) begin
						errors++;
						$display("%0t: length expected %0d, got %0d", $time, want.len, length);
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = predict_list_op(action, position, word_in);
				if (want.st == ST_RANGE)
					range_rejects++;
				if (want.st == ST_FULLEMPTY)
					capacity_rejects++;
				awaited_results.push_back(want);
			end
			waiting = awaited_results.size();
		end
	end

endmodule

// ===== sim/indexed_list_insert_remove_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_tb
// Drives the indexed list block with a directed opening (empty and bad-index
// rejects, word extremes, spare action codes) and then long random runs that
// fill the list to capacity and drain it again, under several idle and stall
// mixes and one long output hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;

	import ilir_pkg::*;

	localparam int      LIST_DEPTH   = 64;
	localparam int      ITEM_TARGET  = 1700;
	localparam int      STALL_LIMIT  = 4000;
	localparam int      HOLD_CYCLES  = 400;
	localparam int      DRAIN_CYCLES = 100;
	localparam action_t ACT_SPARE_LO = 3'd5;
	localparam action_t ACT_SPARE_HI = 3'd7;
	localparam pos_t    POS_TOP      = 7'd127;
	localparam word_t   WORD_MIN     = 32'h8000_0000;
	localparam word_t   WORD_MAX     = 32'h7fff_ffff;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	action_t action;
	pos_t    position;
	word_t   word_in;
	logic    out_valid;
	logic    out_stall;
	word_t   word_out;
	status_t status;
	pos_t    length;

	int fails;
	int level;
	int waiting;
	int checked;
	int range_rejects;
	int capacity_rejects;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int idle_run;
	int sent_per_act [8];
	int n_items;
	bit growing;

	indexed_list_insert_remove #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.position (position),
		.word_in  (word_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_out (word_out),
		.status   (status),
		.length   (length)
	);

	indexed_list_checker #(
		.DEPTH(LIST_DEPTH)
	) list_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.position        (position),
		.word_in         (word_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.word_out        (word_out),
		.status          (status),
		.length          (length),
		.errors          (fails),
		.fill            (level),
		.waiting         (waiting),
		.checked         (checked),
		.range_rejects   (range_rejects),
		.capacity_rejects(capacity_rejects)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver: random stalls, or one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int k = 1; k < HOLD_CYCLES; k++)
					@(negedge clk);
				hold_req = 1'b0;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// No transfer on either channel for too long means the block is stuck.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_run <= 0;
			else if (idle_run >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end else
				idle_run <= idle_run + 1;
		end
	end

	// Called at a negedge, returns at the negedge after the transfer.
	task automatic send_request(action_t act, pos_t pos, word_t val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		word_in  <= val;
		do
			@(posedge clk);
		while (in_stall);
		sent_per_act[act]++;
		@(negedge clk);
	endtask

	// Grow phases favor append/insert, shrink phases remove/drop; positions are
	// mostly legal for the current fill so the shift paths get exercised.
	task automatic send_random_request();
		int      r;
		int      lvl;
		action_t act;
		pos_t    pos;
		word_t   val;
		lvl = level;
		r = $urandom_range(0, 99);
		if (growing)
			act = (r < 30) ? ACT_APPEND : (r < 62) ? ACT_INSERT : (r < 77) ? ACT_READ :
				(r < 87) ? ACT_REMOVE : (r < 95) ? ACT_DROP : ACT_SPARE_LO;
		else
			act = (r < 8) ? ACT_APPEND : (r < 18) ? ACT_INSERT : (r < 33) ? ACT_READ :
				(r < 63) ? ACT_REMOVE : (r < 95) ? ACT_DROP : ACT_SPARE_LO;
		if (act == ACT_SPARE_LO)
			act = action_t'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		if ($urandom_range(0, 99) < 15)
			pos = pos_t'($urandom_range(0, POS_TOP));
		else if (act == ACT_INSERT)
			pos = pos_t'($urandom_range(0, lvl));
		else
			pos = (lvl > 0) ? pos_t'($urandom_range(0, lvl - 1)) : '0;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
			0: val = WORD_MIN;
			1: val = WORD_MAX;
			2: val = '0;
			default: val = '1;
			endcase
		end else
			val = word_t'($urandom);
		send_request(act, pos, val);
		if (act <= ACT_READ)
			n_items++;
		// linger a little at full and empty so the capacity rejects show up
		if (growing && level == LIST_DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (!growing && level == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
	endtask

	initial begin
		int  phase;
		bit  hold_done;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = ACT_APPEND;
		position       = '0;
		word_in        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		hold_done      = 1'b0;
		growing        = 1'b1;
		n_items        = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty-list rejects, then a small list built with extreme words
		send_request(ACT_DROP,   '0, '0);
		send_request(ACT_REMOVE, '0, '0);
		send_request(ACT_READ,   '0, '0);
		send_request(ACT_INSERT, 7'd1, 32'd5);
		send_request(ACT_INSERT, '0, WORD_MIN);
		send_request(ACT_APPEND, '0, WORD_MAX);
		send_request(ACT_APPEND, '0, '1);
		send_request(ACT_APPEND, '0, '0);
		send_request(ACT_INSERT, 7'd4, 32'h1234_5678);  // index equal to count appends
		send_request(ACT_INSERT, 7'd2, 32'ha5a5_a5a5);
		send_request(ACT_READ,   7'd2, '0);
		send_request(ACT_READ,   7'd6, '0);
		send_request(ACT_READ,   POS_TOP, '0);
		send_request(ACT_REMOVE, 7'd5, '0);
		send_request(ACT_REMOVE, '0, '0);
		send_request(ACT_REMOVE, 7'd4, '0);
		send_request(ACT_READ,   '0, '0);
		send_request(ACT_READ,   7'd3, '0);
		send_request(ACT_SPARE_LO, POS_TOP, 32'h5a5a_5a5a);
		send_request(action_t'(3'd6), 7'd1, '1);
		send_request(ACT_SPARE_HI, '0, WORD_MIN);
		send_request(ACT_DROP,   '0, '0);
		send_request(ACT_INSERT, 7'd64, 32'd77);
		send_request(ACT_READ,   7'd1, '0);

		while (n_items < ITEM_TARGET) begin
			phase = n_items * 5 / ITEM_TARGET;
			case (phase)
			1: begin
				send_idle_pct  = 67;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 67;
			end
			3: begin
				send_idle_pct  = 29;
				recv_stall_pct = 29;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			endcase
			// sender keeps offering while the output is held back
			if (phase == 4 && !hold_done) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			send_random_request();
		end
		in_valid <= 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("requests: %0d append, %0d drop, %0d insert, %0d remove, %0d read, %0d spare",
			sent_per_act[ACT_APPEND], sent_per_act[ACT_DROP], sent_per_act[ACT_INSERT],
			sent_per_act[ACT_REMOVE], sent_per_act[ACT_READ],
			sent_per_act[5] + sent_per_act[6] + sent_per_act[7]);
		$display("%0d results compared, %0d bad-index rejects, %0d full/empty rejects",
			checked, range_rejects, capacity_rejects);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
